FILE: rtl/srcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor reply CRC word checker package
// Shared constants, codes and the CRC-8 byte update used by the checker.
// ----------------------------------------------------------------------------
package srcc_pkg;

  localparam int unsigned CRC_BITS = 8;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_TOP_BIT = 8'h80;
  localparam logic [7:0] CRC_POLY_RESET = 8'h31;

  typedef enum logic [1:0] {
    POS_DATA_HI = 2'd0,
    POS_DATA_LO = 2'd1,
    POS_CRC     = 2'd2
  } byte_pos_e;

  typedef enum logic [1:0] {
    FRAME_OK         = 2'd0,
    FRAME_CRC_ERROR  = 2'd1,
    FRAME_INCOMPLETE = 2'd2
  } frame_status_e;

  // MSB-first CRC-8 update over one byte, no reflection.
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data,
                                          input logic [7:0] poly);
    logic [7:0] c;
    logic       top;
    c = crc ^ data;
    for (int k = 0; k < CRC_BITS; k++) begin
      top = |(c & CRC_TOP_BIT);
      c = {c[6:0], 1'b0};
      if (top) begin
        c = c ^ poly;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/sensor_reply_crc_word_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor reply CRC word checker
// Checks three-byte words (two data bytes and a CRC-8 byte) of a sensor reply
// and reports each word, its CRC match and a frame status on the last byte.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                Payload
// input     in         in_valid_i / in_stall_o  rx_byte_i, last_byte_i
// output    out        out_valid_o/ out_stall_i word_done_o, word_value_o,
//                                               word_crc_ok_o, frame_done_o,
//                                               frame_status_o
// config    in         cfg_valid_i/ cfg_ready_o cfg_data_i (crc_polynomial)
//
// One request is accepted per cycle while the input is not stalled; its result
// passes through the input register and then the result register, with the
// unrolled eight-step CRC update between them, and is held there while stalled.
// Reset clears the valid flags, byte position and frame error, sets the
// running CRC to 0xFF and loads the polynomial 0x31. An output stall holds
// the result and backs up into the input register before stalling the input.
// ----------------------------------------------------------------------------
module sensor_reply_crc_word_checker_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       word_done_o,
  output logic [15:0] word_value_o,
  output logic       word_crc_ok_o,
  output logic       frame_done_o,
  output logic [1:0] frame_status_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);
  import srcc_pkg::*;

  logic          in_valid_q;
  logic [7:0]    in_byte_q;
  logic          in_last_q;
  logic          out_valid_q;
  logic          out_ready;
  logic          in_ready;
  logic          fire;

  logic [7:0]    poly_q;
  byte_pos_e     pos_q, pos_d;
  logic [7:0]    crc_q, crc_d;
  logic [7:0]    hi_q, hi_d;
  logic [7:0]    lo_q, lo_d;
  logic          err_q, err_d;

  logic          done_d;
  logic [15:0]   value_d;
  logic          ok_d;
  frame_status_e status_d;
  logic [7:0]    crc_next;

  logic          word_done_q;
  logic [15:0]   word_value_q;
  logic          word_crc_ok_q;
  logic          frame_done_q;
  frame_status_e frame_status_q;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_ready   = !in_valid_q || out_ready;
  assign fire       = in_valid_q && out_ready;
  assign in_stall_o = !in_ready;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= CRC_POLY_RESET;
    end else if (cfg_valid_i) begin
      poly_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      in_byte_q <= rx_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  assign crc_next = crc_fold(crc_q, in_byte_q, poly_q);

  always_comb begin
    pos_d    = pos_q;
    crc_d    = crc_q;
    hi_d     = hi_q;
    lo_d     = lo_q;
    err_d    = err_q;
    done_d   = 1'b0;
    value_d  = '0;
    ok_d     = 1'b0;
    status_d = FRAME_OK;
    case (pos_q)
      POS_DATA_HI: begin
        hi_d  = in_byte_q;
        crc_d = crc_next;
        pos_d = POS_DATA_LO;
      end
      POS_DATA_LO: begin
        lo_d  = in_byte_q;
        crc_d = crc_next;
        pos_d = POS_CRC;
      end
      default: begin
        done_d  = 1'b1;
        value_d = {hi_q, lo_q};
        ok_d    = (crc_q == in_byte_q);
        err_d   = err_q || (crc_q != in_byte_q);
        crc_d   = CRC_INIT;
        pos_d   = POS_DATA_HI;
      end
    endcase
    if (in_last_q) begin
      if (err_d) begin
        status_d = FRAME_CRC_ERROR;
      end else if (pos_d != POS_DATA_HI) begin
        status_d = FRAME_INCOMPLETE;
      end
      pos_d = POS_DATA_HI;
      crc_d = CRC_INIT;
      err_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_DATA_HI;
      crc_q <= CRC_INIT;
      hi_q  <= '0;
      lo_q  <= '0;
      err_q <= 1'b0;
    end else if (fire) begin
      pos_q <= pos_d;
      crc_q <= crc_d;
      hi_q  <= hi_d;
      lo_q  <= lo_d;
      err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      word_done_q    <= done_d;
      word_value_q   <= value_d;
      word_crc_ok_q  <= ok_d;
      frame_done_q   <= in_last_q;
      frame_status_q <= status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign word_done_o    = word_done_q;
  assign word_value_o   = word_value_q;
  assign word_crc_ok_o  = word_crc_ok_q;
  assign frame_done_o   = frame_done_q;
  assign frame_status_o = frame_status_q;

endmodule

FILE: rtl/srcc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor reply CRC word checker port assertions
// Checks result consistency and output hold behavior seen at the ports.
// ----------------------------------------------------------------------------
module srcc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        word_done_o,
  input logic [15:0] word_value_o,
  input logic        word_crc_ok_o,
  input logic        frame_done_o,
  input logic [1:0]  frame_status_o
);
  import srcc_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !word_done_o |-> word_value_o == '0 && !word_crc_ok_o)
    else $error("Word fields set on a request that closes no word.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_done_o |-> frame_status_o == FRAME_OK)
    else $error("Frame status reported without frame end.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frame_status_o == FRAME_OK || frame_status_o == FRAME_CRC_ERROR ||
                    frame_status_o == FRAME_INCOMPLETE)
    else $error("Undefined frame status code.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o && word_done_o && !word_crc_ok_o
      |-> frame_status_o == FRAME_CRC_ERROR)
    else $error("Mismatch on the final word not reflected in frame status.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(word_value_o) &&
                                   $stable(frame_status_o))
    else $error("Stalled result changed.");

endmodule

bind sensor_reply_crc_word_checker_top srcc_checker u_srcc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .word_done_o    (word_done_o),
  .word_value_o   (word_value_o),
  .word_crc_ok_o  (word_crc_ok_o),
  .frame_done_o   (frame_done_o),
  .frame_status_o (frame_status_o)
);
